/* rtl/core/rbcp_pkg.sv */
package rbcp_pkg;

    localparam int Q_W       = 32;   // signed Q16.16 coordinate
    localparam int DIST_W    = 31;   // non-negative distance
    localparam int ID_FIELD_W = 16;  // entity id field on the ports
    localparam int NUM_W     = 48;   // |bound - origin| << 16
    localparam int DEN_W     = 32;   // |direction|
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = 6;
    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES - 1);

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [Q_W-1:0] DIR_Z_RESET = 32'sh0001_0000;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_Z = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_AXIS,
        ST_WAIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [NUM_W-1:0] num_mag;
        logic [DEN_W-1:0] den_mag;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic signed [Q_W-1:0] quot;
    } div_resp_t;

endpackage

/* rtl/core/ray_box_closest_pick.sv */
// Closest-hit ray versus axis-aligned box picker. The ray origin and direction sit in six
// signed Q16.16 registers written through the cfg_* port; the user is to write them only
// while the block is idle, and the block itself does not enforce this. Each input
// transaction carries one box and an entity id; the block runs the slab test on x, y and z,
// dividing (bound - origin) << 16 by the direction on one shared bit-serial divider, and
// returns one result per box: hit flag, entry distance and the closest hit of the current
// pick, with the earlier box winning a tie. An axis whose direction is zero needs no
// division. A non-parallel axis takes one division per slab bound, and the output load and
// the return to idle follow the last axis. s_tready is high only while no box is in work,
// so a new box is accepted only after the result of the box before it is loaded. tlast on
// the input closes the pick: that result carries the final best fields and the pick state
// is cleared.
module ray_box_closest_pick #(
    parameter int ENTITY_ID_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [rbcp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbcp_pkg::Q_W-1:0]        cfg_wdata,
    // box input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, entity_id
    input  logic [207:0]                    s_tdata,
    input  logic                            s_tlast,   // last_box
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // entry_distance, best_entity, best_distance, 2 zero bits
    output logic [79:0]                     m_tdata,
    output logic [1:0]                      m_tuser,   // box_hit, best_found
    output logic                            m_tlast    // pick_done
);

    localparam int ID_W = (ENTITY_ID_BITS < rbcp_pkg::ID_FIELD_W) ?
                          ENTITY_ID_BITS : rbcp_pkg::ID_FIELD_W;

    rbcp_pkg::state_t state_reg, state_next;

    logic signed [rbcp_pkg::Q_W-1:0] org_reg [rbcp_pkg::AXES];
    logic signed [rbcp_pkg::Q_W-1:0] dir_reg [rbcp_pkg::AXES];
    logic signed [rbcp_pkg::Q_W-1:0] lo_reg  [rbcp_pkg::AXES];
    logic signed [rbcp_pkg::Q_W-1:0] hi_reg  [rbcp_pkg::AXES];
    logic [ID_W-1:0]                 id_reg;
    logic                            last_reg;

    logic [rbcp_pkg::AXIS_W-1:0]     axis_reg;
    logic                            half_reg;
    logic                            miss_reg;
    logic signed [rbcp_pkg::Q_W-1:0] t0_reg;
    logic signed [rbcp_pkg::Q_W-1:0] enter_reg;
    logic signed [rbcp_pkg::Q_W-1:0] leave_reg;

    logic [rbcp_pkg::DIST_W-1:0]     closest_dist_reg;
    logic [ID_W-1:0]                 closest_id_reg;
    logic                            any_hit_reg;

    logic                            m_valid_reg;
    logic                            out_hit_reg;
    logic [rbcp_pkg::DIST_W-1:0]     out_entry_reg;
    logic                            out_found_reg;
    logic [ID_W-1:0]                 out_id_reg;
    logic [rbcp_pkg::DIST_W-1:0]     out_dist_reg;
    logic                            out_done_reg;

    logic                            accept;
    logic                            out_load;
    logic                            last_axis;
    logic signed [rbcp_pkg::Q_W-1:0] cur_o;
    logic signed [rbcp_pkg::Q_W-1:0] cur_d;
    logic signed [rbcp_pkg::Q_W-1:0] cur_lo;
    logic signed [rbcp_pkg::Q_W-1:0] cur_hi;
    logic signed [rbcp_pkg::Q_W-1:0] bound;
    logic signed [rbcp_pkg::Q_W:0]   diff;
    logic [rbcp_pkg::Q_W:0]          diff_mag;
    logic [rbcp_pkg::Q_W-1:0]        dir_mag;
    logic                            par_miss;
    logic                            dir_zero;
    logic signed [rbcp_pkg::Q_W-1:0] t_near;
    logic signed [rbcp_pkg::Q_W-1:0] t_far;
    logic                            hit;
    logic [rbcp_pkg::DIST_W-1:0]     hit_dist;
    logic                            take_best;

    rbcp_pkg::div_req_t  div_req;
    rbcp_pkg::div_resp_t div_resp;

    rbcp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == rbcp_pkg::ST_IDLE);
    assign last_axis = (axis_reg == rbcp_pkg::AXIS_LAST);
    assign out_load  = (state_reg == rbcp_pkg::ST_FIN) && (!m_valid_reg || m_tready);

    // per-axis operand selection and slab setup
    always_comb begin
        cur_o    = org_reg[axis_reg];
        cur_d    = dir_reg[axis_reg];
        cur_lo   = lo_reg[axis_reg];
        cur_hi   = hi_reg[axis_reg];
        bound    = half_reg ? cur_hi : cur_lo;
        diff     = {bound[rbcp_pkg::Q_W-1], bound} - {cur_o[rbcp_pkg::Q_W-1], cur_o};
        diff_mag = diff[rbcp_pkg::Q_W] ? (-diff) : diff;
        dir_mag  = cur_d[rbcp_pkg::Q_W-1] ? (-cur_d) : cur_d;
        dir_zero = (cur_d == '0);
        par_miss = (cur_o < cur_lo) || (cur_o > cur_hi);
        t_near   = (t0_reg > div_resp.quot) ? div_resp.quot : t0_reg;
        t_far    = (t0_reg > div_resp.quot) ? t0_reg : div_resp.quot;
    end

    // final hit decision and closest-hit compare
    always_comb begin
        hit       = !miss_reg && (enter_reg <= leave_reg);
        hit_dist  = hit ? enter_reg[rbcp_pkg::DIST_W-1:0] : '0;
        take_best = hit && (!any_hit_reg || (hit_dist < closest_dist_reg));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rbcp_pkg::ST_IDLE: begin
                if (accept) state_next = rbcp_pkg::ST_AXIS;
            end
            rbcp_pkg::ST_AXIS: begin
                if (!dir_zero) begin
                    state_next = rbcp_pkg::ST_WAIT;
                end else if (last_axis) begin
                    state_next = rbcp_pkg::ST_FIN;
                end
            end
            rbcp_pkg::ST_WAIT: begin
                if (div_resp.done) begin
                    state_next = (half_reg && last_axis) ? rbcp_pkg::ST_FIN : rbcp_pkg::ST_AXIS;
                end
            end
            rbcp_pkg::ST_FIN: begin
                if (out_load) state_next = rbcp_pkg::ST_IDLE;
            end
            default: state_next = rbcp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        div_req.start   = 1'b0;
        div_req.neg     = diff[rbcp_pkg::Q_W] ^ cur_d[rbcp_pkg::Q_W-1];
        div_req.num_mag = {diff_mag[rbcp_pkg::Q_W-1:0], 16'h0000};
        div_req.den_mag = dir_mag;
        case (state_reg)
            rbcp_pkg::ST_AXIS: div_req.start = !dir_zero;
            default:           div_req.start = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rbcp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= rbcp_pkg::DIR_Z_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rbcp_pkg::CFG_ORIGIN_X:    org_reg[0] <= cfg_wdata;
                rbcp_pkg::CFG_ORIGIN_Y:    org_reg[1] <= cfg_wdata;
                rbcp_pkg::CFG_ORIGIN_Z:    org_reg[2] <= cfg_wdata;
                rbcp_pkg::CFG_DIRECTION_X: dir_reg[0] <= cfg_wdata;
                rbcp_pkg::CFG_DIRECTION_Y: dir_reg[1] <= cfg_wdata;
                rbcp_pkg::CFG_DIRECTION_Z: dir_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // box capture and slab accumulation
    always_ff @(posedge aclk) begin
        case (state_reg)
            rbcp_pkg::ST_IDLE: begin
                if (accept) begin
                    lo_reg[0] <= s_tdata[31:0];
                    lo_reg[1] <= s_tdata[63:32];
                    lo_reg[2] <= s_tdata[95:64];
                    hi_reg[0] <= s_tdata[127:96];
                    hi_reg[1] <= s_tdata[159:128];
                    hi_reg[2] <= s_tdata[191:160];
                    id_reg    <= s_tdata[192 +: ID_W];
                    last_reg  <= s_tlast;
                    axis_reg  <= '0;
                    half_reg  <= 1'b0;
                    miss_reg  <= 1'b0;
                    enter_reg <= '0;
                    leave_reg <= rbcp_pkg::Q_MAX;
                end
            end
            rbcp_pkg::ST_AXIS: begin
                // parallel axis: no division, only the inside-slab check
                if (dir_zero) begin
                    miss_reg <= miss_reg || par_miss;
                    if (!last_axis) axis_reg <= axis_reg + 1'b1;
                end
            end
            rbcp_pkg::ST_WAIT: begin
                if (div_resp.done) begin
                    if (!half_reg) begin
                        t0_reg   <= div_resp.quot;
                        half_reg <= 1'b1;
                    end else begin
                        half_reg <= 1'b0;
                        if (t_near > enter_reg) enter_reg <= t_near;
                        if (t_far < leave_reg)  leave_reg <= t_far;
                        if (!last_axis) axis_reg <= axis_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // pick state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            closest_dist_reg <= rbcp_pkg::DIST_MAX;
            closest_id_reg   <= '0;
            any_hit_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
                if (last_reg) begin
                    closest_dist_reg <= rbcp_pkg::DIST_MAX;
                    closest_id_reg   <= '0;
                    any_hit_reg      <= 1'b0;
                end else if (take_best) begin
                    closest_dist_reg <= hit_dist;
                    closest_id_reg   <= id_reg;
                    any_hit_reg      <= 1'b1;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_hit_reg   <= hit;
            out_entry_reg <= hit_dist;
            out_found_reg <= any_hit_reg || take_best;
            out_id_reg    <= take_best ? id_reg : closest_id_reg;
            out_dist_reg  <= take_best ? hit_dist : closest_dist_reg;
            out_done_reg  <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_dist_reg, rbcp_pkg::ID_FIELD_W'(out_id_reg), out_entry_reg};
    assign m_tuser  = {out_found_reg, out_hit_reg};
    assign m_tlast  = out_done_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == rbcp_pkg::ST_AXIS) && (axis_reg == '0) && !half_reg)
        else $error("box accepted without starting at the first axis");

    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != rbcp_pkg::ST_IDLE) |-> (axis_reg <= rbcp_pkg::AXIS_LAST))
        else $error("axis counter out of range");

    a_hit_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_hit_reg) |-> out_found_reg)
        else $error("hit reported without a best entry");

    a_no_best: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_found_reg) |->
            (out_dist_reg == rbcp_pkg::DIST_MAX) && (out_id_reg == '0))
        else $error("best fields not at reset values without a hit");

endmodule

/* rtl/core/rbcp_div.sv */
module rbcp_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  rbcp_pkg::div_req_t  req,
    output rbcp_pkg::div_resp_t resp
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [rbcp_pkg::CNT_W-1:0]     cnt_reg;
    logic [rbcp_pkg::DEN_W-1:0]     rem_reg;
    logic [rbcp_pkg::NUM_W-1:0]     numq_reg;
    logic [rbcp_pkg::DEN_W-1:0]     den_reg;
    logic                           neg_reg;

    logic [rbcp_pkg::DEN_W:0]       shifted;
    logic [rbcp_pkg::DEN_W+1:0]     trial;
    logic                           fits;
    logic [rbcp_pkg::DEN_W-1:0]     rem_next;
    logic [rbcp_pkg::NUM_W-1:0]     numq_next;
    logic                           pos_over;
    logic                           neg_over;
    logic signed [rbcp_pkg::Q_W-1:0] quot_sat;

    // one restoring step per cycle while busy; quotient bits shift in behind the dividend
    always_comb begin
        shifted   = {rem_reg, numq_reg[rbcp_pkg::NUM_W-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        fits      = !trial[rbcp_pkg::DEN_W+1];
        rem_next  = fits ? trial[rbcp_pkg::DEN_W-1:0] : shifted[rbcp_pkg::DEN_W-1:0];
        numq_next = {numq_reg[rbcp_pkg::NUM_W-2:0], fits};
    end

    // saturate the signed quotient to the Q16.16 range
    always_comb begin
        pos_over = |numq_reg[rbcp_pkg::NUM_W-1:31];
        neg_over = (|numq_reg[rbcp_pkg::NUM_W-1:32]) || (numq_reg[31] && (|numq_reg[30:0]));
        if (!neg_reg) begin
            quot_sat = pos_over ? rbcp_pkg::Q_MAX : $signed({1'b0, numq_reg[30:0]});
        end else begin
            quot_sat = neg_over ? rbcp_pkg::Q_MIN : $signed(-numq_reg[31:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= rbcp_pkg::CNT_W'(rbcp_pkg::DIV_STEPS - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= '0;
            numq_reg <= req.num_mag;
            den_reg  <= req.den_mag;
            neg_reg  <= req.neg;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            numq_reg <= numq_next;
        end
    end

    assign resp.busy = busy_reg;
    assign resp.done = done_reg;
    assign resp.quot = quot_sat;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a finished run");

endmodule
